FILE: rtl/vlsw_pkg.sv
// Shared types, constants and helper functions of the valve link safety watchdog.
package vlsw_pkg;

   // Field widths
   localparam int TimeWidth     = 48;
   localparam int CfgWidth      = 22;
   localparam int CsrIndexWidth = 8;

   // Configuration register indexes
   localparam logic [CsrIndexWidth-1:0] RegCommandTimeout   = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] RegAdvertiseTimeout = CsrIndexWidth'(1);
   localparam logic [CsrIndexWidth-1:0] RegReconnectTimeout = CsrIndexWidth'(2);
   localparam logic [CsrIndexWidth-1:0] RegInconsistency    = CsrIndexWidth'(3);

   // Configuration reset values
   localparam logic [CfgWidth-1:0] CommandTimeoutReset   = CfgWidth'(5000);
   localparam logic [CfgWidth-1:0] AdvertiseTimeoutReset = CfgWidth'(30000);
   localparam logic [CfgWidth-1:0] ReconnectTimeoutReset = CfgWidth'(60000);
   localparam logic [CfgWidth-1:0] InconsistencyReset    = CfgWidth'(2000);

   // Item function codes
   localparam logic FuncTick = 1'b0;
   localparam logic FuncKick = 1'b1;

   // Valve stop codes
   localparam logic [1:0] StopNone      = 2'd0;
   localparam logic [1:0] StopReconnect = 2'd1;
   localparam logic [1:0] StopCommand   = 2'd2;

   typedef logic [TimeWidth-1:0] time_type;
   typedef logic [CfgWidth-1:0]  cfg_value_type;

   typedef struct packed {
      logic     func;
      time_type now_ms;
      logic     link_connected;
      logic     valve_open;
      logic     running;
   } item_type;

   typedef struct packed {
      cfg_value_type command_timeout_ms;
      cfg_value_type advertise_timeout_ms;
      cfg_value_type reconnect_timeout_ms;
      cfg_value_type inconsistency_ms;
   } cfg_type;

   typedef struct packed {
      logic       restart_advertising;
      logic [1:0] valve_stop;
      logic       send_error;
      logic       reset_to_idle;
      logic       disconnect_noted;
   } result_type;

   // True when the wrapped time since a mark is at least the limit.
   function automatic logic elapsed_ge(time_type now, time_type since, cfg_value_type limit);
      time_type diff;
      diff = now - since;
      return diff >= {{(TimeWidth-CfgWidth){1'b0}}, limit};
   endfunction

   // True when the wrapped time since a mark is strictly above the limit.
   function automatic logic elapsed_gt(time_type now, time_type since, cfg_value_type limit);
      time_type diff;
      diff = now - since;
      return diff > {{(TimeWidth-CfgWidth){1'b0}}, limit};
   endfunction

endpackage

FILE: rtl/vlsw_if.sv
// Channel interfaces of the valve link safety watchdog: items, results and register writes.
interface vlsw_req_if import vlsw_pkg::*; ();
   logic     valid;
   logic     ready;
   logic     func;
   time_type now_ms;
   logic     link_connected;
   logic     valve_open;
   logic     running;

   modport source (output valid, func, now_ms, link_connected, valve_open, running,
                   input ready);
   modport sink   (input valid, func, now_ms, link_connected, valve_open, running,
                   output ready);
endinterface

interface vlsw_rsp_if import vlsw_pkg::*; ();
   logic       valid;
   logic       ready;
   logic       restart_advertising;
   logic [1:0] valve_stop;
   logic       send_error;
   logic       reset_to_idle;
   logic       disconnect_noted;

   modport source (output valid, restart_advertising, valve_stop, send_error, reset_to_idle,
                   disconnect_noted, input ready);
   modport sink   (input valid, restart_advertising, valve_stop, send_error, reset_to_idle,
                   disconnect_noted, output ready);
endinterface

interface vlsw_csr_if import vlsw_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   cfg_value_type            data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/vlsw_core.sv
// Timer state and check logic of the valve link safety watchdog for one item.
module vlsw_core import vlsw_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   input  cfg_type    cfg,
   output result_type result
);

   time_type last_cmd_ff, last_cmd_in;
   time_type no_link_since_ff, no_link_since_in;
   logic     no_link_armed_ff, no_link_armed_in;
   time_type lost_link_since_ff, lost_link_since_in;
   logic     lost_link_armed_ff, lost_link_armed_in;
   time_type mismatch_since_ff, mismatch_since_in;
   logic     mismatch_armed_ff, mismatch_armed_in;

   logic adv_due;
   logic reconnect_due;
   logic command_due;
   logic mismatch_due;
   logic skip_rest;
   logic closed;

   // The comparisons run in parallel on the registered marks.
   assign adv_due       = elapsed_ge(item.now_ms, no_link_since_ff, cfg.advertise_timeout_ms);
   assign mismatch_due  = elapsed_gt(item.now_ms, mismatch_since_ff, cfg.inconsistency_ms);
   // A freshly armed reconnect mark has zero elapsed time.
   assign reconnect_due = lost_link_armed_ff
                          ? elapsed_ge(item.now_ms, lost_link_since_ff, cfg.reconnect_timeout_ms)
                          : (cfg.reconnect_timeout_ms == '0);
   // A reconnect moves the last command time to now, giving zero elapsed time.
   assign command_due   = lost_link_armed_ff
                          ? (cfg.command_timeout_ms == '0)
                          : elapsed_ge(item.now_ms, last_cmd_ff, cfg.command_timeout_ms);

   // The four checks in order, producing the result and the next timer state.
   always_comb begin
      last_cmd_in        = last_cmd_ff;
      no_link_since_in   = no_link_since_ff;
      no_link_armed_in   = no_link_armed_ff;
      lost_link_since_in = lost_link_since_ff;
      lost_link_armed_in = lost_link_armed_ff;
      mismatch_since_in  = mismatch_since_ff;
      mismatch_armed_in  = mismatch_armed_ff;
      result             = '0;
      skip_rest          = 1'b0;
      closed             = 1'b0;

      if (item.func == FuncKick) begin
         last_cmd_in = item.now_ms;
      end else begin
         // Advertising timer
         if (!item.link_connected) begin
            if (!no_link_armed_ff) begin
               no_link_armed_in = 1'b1;
               no_link_since_in = item.now_ms;
            end else if (adv_due) begin
               result.restart_advertising = 1'b1;
               no_link_since_in           = item.now_ms;
            end
         end else begin
            no_link_armed_in = 1'b0;
         end

         // Reconnect and command timers
         if (item.valve_open && item.running) begin
            if (!item.link_connected) begin
               if (!lost_link_armed_ff) begin
                  lost_link_armed_in      = 1'b1;
                  lost_link_since_in      = item.now_ms;
                  result.disconnect_noted = 1'b1;
               end
               if (reconnect_due) begin
                  result.valve_stop  = StopReconnect;
                  lost_link_armed_in = 1'b0;
               end
               skip_rest = 1'b1;
            end else begin
               if (lost_link_armed_ff) begin
                  lost_link_armed_in = 1'b0;
                  last_cmd_in        = item.now_ms;
               end
               if (command_due) begin
                  result.valve_stop = StopCommand;
                  result.send_error = 1'b1;
               end
            end
         end else begin
            lost_link_armed_in = 1'b0;
         end

         // Inconsistency timer; a stop this tick counts as a closed valve.
         if (!skip_rest) begin
            closed = !item.valve_open || (result.valve_stop != StopNone);
            if (item.running && closed) begin
               if (!mismatch_armed_ff) begin
                  mismatch_armed_in = 1'b1;
                  mismatch_since_in = item.now_ms;
               end else if (mismatch_due) begin
                  result.reset_to_idle = 1'b1;
                  mismatch_armed_in    = 1'b0;
               end
            end else begin
               mismatch_armed_in = 1'b0;
            end
         end
      end
   end

   // Timer state, updated once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         last_cmd_ff        <= '0;
         no_link_since_ff   <= '0;
         no_link_armed_ff   <= 1'b0;
         lost_link_since_ff <= '0;
         lost_link_armed_ff <= 1'b0;
         mismatch_since_ff  <= '0;
         mismatch_armed_ff  <= 1'b0;
      end else if (step) begin
         last_cmd_ff        <= last_cmd_in;
         no_link_since_ff   <= no_link_since_in;
         no_link_armed_ff   <= no_link_armed_in;
         lost_link_since_ff <= lost_link_since_in;
         lost_link_armed_ff <= lost_link_armed_in;
         mismatch_since_ff  <= mismatch_since_in;
         mismatch_armed_ff  <= mismatch_armed_in;
      end
   end

   // An error message goes out exactly with a command timeout stop.
   a_error_with_command_stop: assert property (@(posedge clock) disable iff (reset)
      step |-> (result.send_error == (result.valve_stop == StopCommand)))
      else $error("send_error and command stop disagree");

   // A kick raises no request.
   a_kick_quiet: assert property (@(posedge clock) disable iff (reset)
      (step && item.func == FuncKick) |-> (result == '0))
      else $error("kick produced a request");

   // A kick records its time as the last command time.
   a_kick_records: assert property (@(posedge clock) disable iff (reset)
      (step && item.func == FuncKick) |=> (last_cmd_ff == $past(item.now_ms)))
      else $error("kick did not record the command time");

   // A disconnect is noted only while the reconnect timer is disarmed.
   a_noted_once: assert property (@(posedge clock) disable iff (reset)
      (step && result.disconnect_noted) |-> !lost_link_armed_ff)
      else $error("disconnect noted with the reconnect timer already armed");

endmodule

FILE: rtl/valve_link_safety_watchdog.sv
// Top level of the valve link safety watchdog: channels, registers and item pipeline.
//
// The req_ch channel carries one item per transfer: a kick (func = 1) records
// now_ms as the time of the last command, a tick (func = 0) runs the advertising,
// reconnect, command and inconsistency checks against the millisecond time.
// Every item gives exactly one result transfer on rsp_ch, in order; a kick's
// result has every request flag clear.
// The csr_ch channel writes the four timeout registers by index (0 command,
// 1 advertise, 2 reconnect, 3 inconsistency); other indexes are ignored. It is
// always ready and should be used only while no item is in flight.
// An item taken on req_ch is held in the item register, passes through the check
// logic and is loaded into the result register, which drives rsp_ch. Throughput:
// one item per cycle while rsp_ch takes each result.
// When rsp_ch stalls, the result register holds and the item register still
// takes one more item; req_ch.ready falls once both are full.
// Reset clears all timer marks and armed flags, empties both registers and
// restores the register defaults (5000, 30000, 60000 and 2000 ms).
module valve_link_safety_watchdog import vlsw_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   vlsw_req_if.sink      req_ch,
   vlsw_rsp_if.source    rsp_ch,
   vlsw_csr_if.sink      csr_ch
);

   item_type   item_ff;
   logic       item_valid_ff, item_valid_in;
   result_type result_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   cfg_type    cfg_ff;
   result_type result;
   logic       advance;
   logic       req_take;

   // Flow control: the item register moves on when the result register is free.
   assign advance       = item_valid_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !item_valid_ff || advance;
   assign req_take      = req_ch.valid && req_ch.ready;
   assign item_valid_in = req_take || (item_valid_ff && !advance);
   assign rsp_valid_in  = advance || (rsp_valid_ff && !rsp_ch.ready);

   // Control state of the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Item register, loaded on each input transfer.
   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff.func           <= req_ch.func;
         item_ff.now_ms         <= req_ch.now_ms;
         item_ff.link_connected <= req_ch.link_connected;
         item_ff.valve_open     <= req_ch.valve_open;
         item_ff.running        <= req_ch.running;
      end
   end

   // Result register, loaded as the item leaves the first stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   // Configuration registers.
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.command_timeout_ms   <= CommandTimeoutReset;
         cfg_ff.advertise_timeout_ms <= AdvertiseTimeoutReset;
         cfg_ff.reconnect_timeout_ms <= ReconnectTimeoutReset;
         cfg_ff.inconsistency_ms     <= InconsistencyReset;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            RegCommandTimeout:   cfg_ff.command_timeout_ms   <= csr_ch.data;
            RegAdvertiseTimeout: cfg_ff.advertise_timeout_ms <= csr_ch.data;
            RegReconnectTimeout: cfg_ff.reconnect_timeout_ms <= csr_ch.data;
            RegInconsistency:    cfg_ff.inconsistency_ms     <= csr_ch.data;
            default: begin
            end
         endcase
      end
   end

   // Check logic and timer state.
   vlsw_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   // Result channel.
   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.restart_advertising = result_ff.restart_advertising;
   assign rsp_ch.valve_stop          = result_ff.valve_stop;
   assign rsp_ch.send_error          = result_ff.send_error;
   assign rsp_ch.reset_to_idle       = result_ff.reset_to_idle;
   assign rsp_ch.disconnect_noted    = result_ff.disconnect_noted;

endmodule

FILE: dv/testbench.sv
// Self-checking testbench of the valve link safety watchdog with its own timer predictor.
`timescale 1ns / 1ps

module testbench;
   import vlsw_pkg::*;

   localparam int ClockHalf    = 4;
   localparam int ResetCycles  = 5;
   localparam int QuietLimit   = 5000;
   localparam int PhaseItems   = 190;
   localparam int PhaseCount   = 6;
   localparam int IdlePct      = 65;
   localparam int BothPct      = 11;
   localparam int HoldCycles   = 60;
   localparam int SettleCycles = 4;
   localparam int PrintLimit   = 40;
   localparam cfg_value_type CfgMax = '1;
   localparam result_type Quiet = '0;

   typedef enum int {PaceFull, PaceSenderIdle, PaceReceiverStall, PaceBoth} pace_type;

   typedef struct {
      item_type   stim;
      logic       typed;
      result_type flags;
   } directed_row_type;

   logic clock;
   logic reset;

   vlsw_req_if req_ch ();
   vlsw_rsp_if rsp_ch ();
   vlsw_csr_if csr_ch ();

   valve_link_safety_watchdog uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   // Predictor copy of the timeouts and the timer marks.
   cfg_type  timeouts;
   time_type cmd_mark;
   time_type no_link_mark;
   time_type lost_link_mark;
   time_type mismatch_mark;
   logic     no_link_armed;
   logic     lost_link_armed;
   logic     mismatch_armed;

   // Expected request flags, oldest first.
   result_type flags_due[$];
   directed_row_type directed_rows[$];

   int unsigned mismatches;
   int unsigned results_seen;
   int          gap_pct;
   int          stall_pct;
   int          rsp_hold_cycles;

   // Slowly changing plant conditions for the random part.
   time_type wall_ms;
   logic     link_up;
   logic     valve_is_open;
   logic     is_running;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   // Wrapped time since a mark, modulo the time width.
   function automatic time_type elapsed_ms(time_type at, time_type mark);
      return at - mark;
   endfunction

   // Works out the request flags of one item and advances the timer marks.
   function automatic result_type supervise(item_type it);
      result_type r;
      logic       closed;
      r = Quiet;
      if (it.func == FuncKick) begin
         cmd_mark = it.now_ms;
         return r;
      end

      // Advertising timer.
      if (!it.link_connected) begin
         if (!no_link_armed) begin
            no_link_armed = 1'b1;
            no_link_mark  = it.now_ms;
         end else if (elapsed_ms(it.now_ms, no_link_mark) >=
                      time_type'(timeouts.advertise_timeout_ms)) begin
            r.restart_advertising = 1'b1;
            no_link_mark = it.now_ms;
         end
      end else begin
         no_link_armed = 1'b0;
      end

      // Link lost while dispensing: only the reconnect timer runs.
      if (it.valve_open && it.running && !it.link_connected) begin
         if (!lost_link_armed) begin
            lost_link_armed    = 1'b1;
            lost_link_mark     = it.now_ms;
            r.disconnect_noted = 1'b1;
         end
         if (elapsed_ms(it.now_ms, lost_link_mark) >=
             time_type'(timeouts.reconnect_timeout_ms)) begin
            r.valve_stop    = StopReconnect;
            lost_link_armed = 1'b0;
         end
         return r;
      end

      // Reconnection counts as a command; then the command timer.
      if (it.valve_open && it.running) begin
         if (lost_link_armed) begin
            lost_link_armed = 1'b0;
            cmd_mark = it.now_ms;
         end
         if (elapsed_ms(it.now_ms, cmd_mark) >= time_type'(timeouts.command_timeout_ms)) begin
            r.valve_stop = StopCommand;
            r.send_error = 1'b1;
         end
      end else begin
         lost_link_armed = 1'b0;
      end

      // Inconsistency timer; a stop in this tick counts as a closed valve.
      closed = !it.valve_open || (r.valve_stop != StopNone);
      if (it.running && closed) begin
         if (!mismatch_armed) begin
            mismatch_armed = 1'b1;
            mismatch_mark  = it.now_ms;
         end else if (elapsed_ms(it.now_ms, mismatch_mark) >
                      time_type'(timeouts.inconsistency_ms)) begin
            r.reset_to_idle = 1'b1;
            mismatch_armed  = 1'b0;
         end
      end else begin
         mismatch_armed = 1'b0;
      end
      return r;
   endfunction

   task automatic report_mismatch(string what, longint unsigned want, longint unsigned got);
      if (mismatches < PrintLimit) begin
         $display("%0t: result %0d, %s: expected %0d, got %0d",
                  $time, results_seen, what, want, got);
      end
      mismatches++;
   endtask

   task automatic set_pace(pace_type pace);
      case (pace)
         PaceFull: begin
            gap_pct   = 0;
            stall_pct = 0;
         end
         PaceSenderIdle: begin
            gap_pct   = IdlePct;
            stall_pct = 0;
         end
         PaceReceiverStall: begin
            gap_pct   = 0;
            stall_pct = IdlePct;
         end
         default: begin
            gap_pct   = BothPct;
            stall_pct = BothPct;
         end
      endcase
   endtask

   // One register write; valid is lowered again after the transfer.
   task automatic set_register(logic [CsrIndexWidth-1:0] index, cfg_value_type value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= value;
      do @(posedge clock); while (!csr_ch.ready);
      case (index)
         RegCommandTimeout:   timeouts.command_timeout_ms   = value;
         RegAdvertiseTimeout: timeouts.advertise_timeout_ms = value;
         RegReconnectTimeout: timeouts.reconnect_timeout_ms = value;
         RegInconsistency:    timeouts.inconsistency_ms     = value;
         default: ;
      endcase
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_timeouts(cfg_value_type command, cfg_value_type advertise,
                                cfg_value_type reconnect, cfg_value_type inconsistency);
      set_register(RegCommandTimeout, command);
      set_register(RegAdvertiseTimeout, advertise);
      set_register(RegReconnectTimeout, reconnect);
      set_register(RegInconsistency, inconsistency);
   endtask

   // Offers one item after a random gap and records its expected flags on transfer.
   task automatic send_item(item_type it, logic typed, result_type want);
      result_type outcome;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.func           <= it.func;
      req_ch.now_ms         <= it.now_ms;
      req_ch.link_connected <= it.link_connected;
      req_ch.valve_open     <= it.valve_open;
      req_ch.running        <= it.running;
      do @(posedge clock); while (!req_ch.ready);
      outcome = supervise(it);
      flags_due.push_back(typed ? want : outcome);
   endtask

   // Stops offering and waits until every result has come back.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (flags_due.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic add_row(logic func, time_type at, logic link, logic open, logic run,
                          logic typed, result_type flags);
      directed_row_type row;
      row.stim.func           = func;
      row.stim.now_ms         = at;
      row.stim.link_connected = link;
      row.stim.valve_open     = open;
      row.stim.running        = run;
      row.typed = typed;
      row.flags = flags;
      directed_rows.push_back(row);
   endtask

   // Random item: mostly a monotonic clock with conditions that persist over several
   // ticks, steps sized around the timeouts, and a little noise in the time.
   function automatic item_type random_item();
      item_type        it;
      cfg_value_type   span;
      longint unsigned step;
      int unsigned     pick;
      case ($urandom_range(3))
         0:       span = timeouts.command_timeout_ms;
         1:       span = timeouts.advertise_timeout_ms;
         2:       span = timeouts.reconnect_timeout_ms;
         default: span = timeouts.inconsistency_ms;
      endcase
      if ($urandom_range(99) < 12) link_up       = ~link_up;
      if ($urandom_range(99) < 12) valve_is_open = ~valve_is_open;
      if ($urandom_range(99) < 8)  is_running    = ~is_running;

      pick = $urandom_range(99);
      if (pick < 35) begin
         step = 64'($urandom_range(0, 60));
      end else if (pick < 70) begin
         step = 64'($urandom_range(0, span / 2 + 1));
      end else if (pick < 92) begin
         step = longint'(span) + $urandom_range(0, 2);
         if (step != 0) step = step - 1;
      end else begin
         step = 64'($urandom);
      end
      wall_ms = wall_ms + time_type'(step);

      it.func           = ($urandom_range(99) < 15) ? FuncKick : FuncTick;
      it.now_ms         = wall_ms;
      it.link_connected = link_up;
      it.valve_open     = valve_is_open;
      it.running        = is_running;
      if ($urandom_range(99) < 5) begin
         it.now_ms         = time_type'({$urandom, $urandom});
         it.link_connected = 1'($urandom_range(1));
         it.valve_open     = 1'($urandom_range(1));
         it.running        = 1'($urandom_range(1));
      end
      return it;
   endfunction

   // Receiver: checks each result transfer and drives ready.
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (flags_due.size() == 0) begin
               report_mismatch("result with nothing expected", 0, 1);
            end else begin
               result_type want;
               want = flags_due.pop_front();
               if (rsp_ch.restart_advertising !== want.restart_advertising)
                  report_mismatch("restart_advertising", 64'(want.restart_advertising),
                                  64'(rsp_ch.restart_advertising));
               if (rsp_ch.valve_stop !== want.valve_stop)
                  report_mismatch("valve_stop", 64'(want.valve_stop),
                                  64'(rsp_ch.valve_stop));
               if (rsp_ch.send_error !== want.send_error)
                  report_mismatch("send_error", 64'(want.send_error),
                                  64'(rsp_ch.send_error));
               if (rsp_ch.reset_to_idle !== want.reset_to_idle)
                  report_mismatch("reset_to_idle", 64'(want.reset_to_idle),
                                  64'(rsp_ch.reset_to_idle));
               if (rsp_ch.disconnect_noted !== want.disconnect_noted)
                  report_mismatch("disconnect_noted", 64'(want.disconnect_noted),
                                  64'(rsp_ch.disconnect_noted));
            end
            results_seen++;
         end
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Ends the run when no transfer of any kind happens for too long.
   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("watchdog: no transfer for %0d cycles", QuietLimit);
      $display("** valve_link_safety_watchdog: FAILED **");
      $finish;
   end

   // Main sequence: reset, directed table, then random phases.
   initial begin
      item_type it;
      directed_row_type row;

      reset                 <= 1'b1;
      req_ch.valid          <= 1'b0;
      req_ch.func           <= FuncTick;
      req_ch.now_ms         <= '0;
      req_ch.link_connected <= 1'b0;
      req_ch.valve_open     <= 1'b0;
      req_ch.running        <= 1'b0;
      csr_ch.valid          <= 1'b0;
      csr_ch.index          <= RegCommandTimeout;
      csr_ch.data           <= '0;
      mismatches      = 0;
      results_seen    = 0;
      rsp_hold_cycles = 0;
      set_pace(PaceFull);

      timeouts.command_timeout_ms   = CommandTimeoutReset;
      timeouts.advertise_timeout_ms = AdvertiseTimeoutReset;
      timeouts.reconnect_timeout_ms = ReconnectTimeoutReset;
      timeouts.inconsistency_ms     = InconsistencyReset;
      cmd_mark        = '0;
      no_link_mark    = '0;
      lost_link_mark  = '0;
      mismatch_mark   = '0;
      no_link_armed   = 1'b0;
      lost_link_armed = 1'b0;
      mismatch_armed  = 1'b0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table at the reset timeouts (5000, 30000, 60000, 2000 ms).
      // A kick after reset gives no flags.
      add_row(FuncKick, 48'd0, 1'b0, 1'b0, 1'b0, 1'b1, Quiet);
      add_row(FuncTick, 48'd100, 1'b1, 1'b0, 1'b0, 1'b1, Quiet);
      // Link down arms the advertising timer; exactly one timeout later it fires.
      add_row(FuncTick, 48'd200, 1'b0, 1'b0, 1'b0, 1'b1, Quiet);
      add_row(FuncTick, 48'd30200, 1'b0, 1'b0, 1'b0, 1'b1,
              result_type'({1'b1, StopNone, 1'b0, 1'b0, 1'b0}));
      // Link lost while dispensing is noted, and the valve stops at the reconnect timeout.
      add_row(FuncTick, 48'd30300, 1'b0, 1'b1, 1'b1, 1'b1,
              result_type'({1'b0, StopNone, 1'b0, 1'b0, 1'b1}));
      add_row(FuncTick, 48'd90300, 1'b0, 1'b1, 1'b1, 1'b1,
              result_type'({1'b1, StopReconnect, 1'b0, 1'b0, 1'b0}));
      // Back online with no recent command: command stop and error.
      add_row(FuncTick, 48'd90400, 1'b1, 1'b1, 1'b1, 1'b1,
              result_type'({1'b0, StopCommand, 1'b1, 1'b0, 1'b0}));
      // Running with a closed valve: the limit itself is not enough, one more ms is.
      add_row(FuncTick, 48'd92400, 1'b1, 1'b0, 1'b1, 1'b1, Quiet);
      add_row(FuncTick, 48'd92401, 1'b1, 1'b0, 1'b1, 1'b1,
              result_type'({1'b0, StopNone, 1'b0, 1'b1, 1'b0}));
      // Reconnect within the window refreshes the command time.
      add_row(FuncKick, 48'd100000, 1'b1, 1'b1, 1'b1, 1'b1, Quiet);
      add_row(FuncTick, 48'd100100, 1'b1, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'd101000, 1'b0, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'd102000, 1'b1, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'd106999, 1'b1, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'd107000, 1'b1, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'd107100, 1'b1, 1'b1, 1'b0, 1'b0, Quiet);
      // Time wrapping past the top of the counter.
      add_row(FuncKick, 48'hFFFF_FFFF_FFF6, 1'b1, 1'b1, 1'b1, 1'b1, Quiet);
      add_row(FuncTick, 48'd5, 1'b1, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'hFFFF_FFFF_FFFF, 1'b0, 1'b1, 1'b1, 1'b0, Quiet);
      add_row(FuncTick, 48'hFFFF_FFFF_FFFF, 1'b1, 1'b0, 1'b1, 1'b0, Quiet);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         send_item(row.stim, row.typed, row.flags);
      end
      drain();

      // Random phases, each with its own timeouts and pacing.
      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: begin
               set_pace(PaceFull);
               rsp_hold_cycles = HoldCycles;
            end
            1: begin
               load_timeouts('0, '0, '0, '0);
               set_pace(PaceSenderIdle);
            end
            2: begin
               load_timeouts(CfgMax, CfgMax, CfgMax, CfgMax);
               set_register(CsrIndexWidth'($urandom_range(RegInconsistency + 1, 255)),
                            cfg_value_type'($urandom));
               set_pace(PaceReceiverStall);
            end
            3: begin
               load_timeouts(cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)));
               set_pace(PaceBoth);
            end
            4: begin
               load_timeouts(cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)),
                             cfg_value_type'($urandom_range(0, 3000)));
               set_pace(PaceFull);
            end
            default: begin
               load_timeouts(cfg_value_type'($urandom_range(1, 400)),
                             cfg_value_type'($urandom_range(1, 400)),
                             cfg_value_type'($urandom_range(1, 400)),
                             cfg_value_type'($urandom_range(1, 400)));
               set_pace(PaceSenderIdle);
            end
         endcase

         // Phase four starts just below the top of the counter so that time wraps.
         if (phase == 4) wall_ms = time_type'('1) - time_type'($urandom_range(0, 20000));
         else            wall_ms = time_type'({$urandom, $urandom});
         link_up       = 1'($urandom_range(1));
         valve_is_open = 1'($urandom_range(1));
         is_running    = 1'($urandom_range(1));

         for (int n = 0; n < PhaseItems; n++) begin
            it = random_item();
            send_item(it, 1'b0, Quiet);
         end
         drain();
      end

      repeat (SettleCycles) @(posedge clock);
      if (mismatches == 0)
         $display("** valve_link_safety_watchdog: PASSED **");
      else
         $display("** valve_link_safety_watchdog: FAILED **");
      $finish;
   end

endmodule

FILE: valve_link_safety_watchdog.f
rtl/vlsw_pkg.sv
rtl/vlsw_if.sv
rtl/vlsw_core.sv
rtl/valve_link_safety_watchdog.sv
dv/testbench.sv
